// ===== rtl/binomial_coefficient_saturating_assert.svh =====
// Assertion macros used by the top RTL file of the binomial coefficient block.
`ifndef BINOMIAL_COEFFICIENT_SATURATING_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_SATURATING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bcs_pkg.sv =====
`default_nettype none
package bcs_pkg;
  localparam int NW = 32;          // width of n and k
  localparam int CW = 31;          // width of the running value and factors
  localparam int PW = 2 * CW;      // width of a product
  localparam int IW = 5;           // width of the round index (at most 17)
  localparam int PCW = 6;          // width of the divider bit counter
  localparam int MCW = 5;          // width of the multiplier bit counter
  localparam logic [CW-1:0] COMB_SAT = {CW{1'b1}};
endpackage
`default_nettype wire

// ===== rtl/binomial_coefficient_saturating.sv =====
// Saturating binomial coefficient C(n,k).
// Input channel (in_*): one transaction carries n in in_tdata[31:0] and k in
// in_tdata[63:32], both two's complement. Output channel (out_*): one
// transaction per input, C(n,k) in out_tdata[30:0], zero when n or k is
// negative or k exceeds n, and 2147483647 once the value would exceed it.
// The block takes one transaction at a time. After acceptance S_CHECK
// checks the operands and S_ORIENT folds k to min(k, n-k). Each round of
// c = c * (n-k+i) / i then runs the shift-and-add multiplier, then the
// restoring divider, with handoffs through S_MSTART, S_MWAIT and S_DWAIT.
// At most 17 rounds run before saturation. Invalid operands go from S_CHECK
// straight to S_FIN, C(n,0) and C(n,n) go there from S_ORIENT, and the block
// is ready for the next transaction once its result enters the output register.
// The result waits in an output register; a new transaction is accepted
// while it waits, and only the next result is held back if the receiver
// still stalls. Synchronous active-low reset empties the output register
// and returns the controller to idle.
`default_nettype none
module binomial_coefficient_saturating
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] set_size, [63:32] choose_count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [30:0] combinations, [31] zero
);
  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_ORIENT, S_MSTART, S_MWAIT, S_DWAIT, S_FIN
  } state_t;

  state_t               state_r;
  logic signed [NW-1:0] n_r;
  logic signed [NW-1:0] k_r;
  logic [CW-1:0]        diff_r;
  logic [CW-1:0]        kk_r;
  logic [CW-1:0]        factor_r;
  logic [CW-1:0]        c_r;
  logic [IW-1:0]        i_r;
  logic [CW-1:0]        res_r;
  logic [CW-1:0]        out_data_r;
  logic                 out_valid_r;

  logic                 in_fire;
  logic                 mul_start;
  logic                 mul_done;
  logic [PW-1:0]        product;
  logic                 div_done;
  logic [PW-1:0]        quotient;
  logic                 over;
  logic [NW-1:0]        diff_full;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign mul_start = (state_r == S_MSTART);
  assign over      = |quotient[PW-1:CW];
  assign diff_full = n_r - k_r;

  bcs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (c_r),
    .mplier  (factor_r),
    .done    (mul_done),
    .product (product)
  );

  bcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (product),
    .divisor  (i_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In S_FIN the output register is reloaded below instead.
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            n_r     <= in_tdata[31:0];
            k_r     <= in_tdata[63:32];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (n_r[NW-1] || k_r[NW-1] || (k_r > n_r)) begin
            res_r   <= '0;
            state_r <= S_FIN;
          end else begin
            diff_r  <= diff_full[CW-1:0];
            state_r <= S_ORIENT;
          end
        end
        S_ORIENT: begin
          // With k folded to n-k, the base n-k of the product becomes k itself.
          if (k_r[CW-1:0] > diff_r) begin
            kk_r     <= diff_r;
            factor_r <= k_r[CW-1:0] + 1'b1;
          end else begin
            kk_r     <= k_r[CW-1:0];
            factor_r <= diff_r + 1'b1;
          end
          c_r <= CW'(1);
          i_r <= IW'(1);
          if (k_r[CW-1:0] == '0 || diff_r == '0) begin
            res_r   <= CW'(1);
            state_r <= S_FIN;
          end else begin
            state_r <= S_MSTART;
          end
        end
        S_MSTART: begin
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            state_r <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            if (over) begin
              res_r   <= COMB_SAT;
              state_r <= S_FIN;
            end else if ({{(CW-IW){1'b0}}, i_r} == kk_r) begin
              res_r   <= quotient[CW-1:0];
              state_r <= S_FIN;
            end else begin
              c_r      <= quotient[CW-1:0];
              i_r      <= i_r + 1'b1;
              factor_r <= factor_r + 1'b1;
              state_r  <= S_MSTART;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

`include "binomial_coefficient_saturating_assert.svh"

  `BCS_ASSERT_NEXT(a_accept_to_check, in_fire, state_r == S_CHECK, "accept did not start a check")
  `BCS_ASSERT_NOW(a_mul_done_state, mul_done, state_r == S_MWAIT, "multiplier finished out of turn")
  `BCS_ASSERT_NOW(a_div_done_state, div_done, state_r == S_DWAIT, "divider finished out of turn")
  `BCS_ASSERT_NOW(a_quot_nonzero, div_done && !over, quotient != '0, "running value became zero")

endmodule
`default_nettype wire

// ===== rtl/bcs_mul.sv =====
`default_nettype none
module bcs_mul
  import bcs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW-1:0] mcand,
  input  wire logic [CW-1:0] mplier,
  output logic               done,
  output logic [PW-1:0]      product
);
  // Shift-and-add multiplier: one multiplier bit retires per cycle.
  logic [CW-1:0]  mc_r;
  logic [CW-1:0]  hi_r;
  logic [CW-1:0]  lo_r;
  logic [MCW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [CW:0]    sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : {(CW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mc_r   <= mcand;
        hi_r   <= '0;
        lo_r   <= mplier;
      end else if (busy_r) begin
        hi_r  <= sum[CW:1];
        lo_r  <= {sum[0], lo_r[CW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MCW'(CW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};
endmodule
`default_nettype wire

// ===== rtl/bcs_div.sv =====
`default_nettype none
module bcs_div
  import bcs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [IW-1:0] divisor,
  output logic               done,
  output logic [PW-1:0]      quotient
);
  // Restoring divider by a small divisor: one quotient bit per cycle.
  // The dividend shifts out at the top while quotient bits enter at the bottom.
  logic [PW-1:0]  q_r;
  logic [IW-1:0]  rem_r;
  logic [IW-1:0]  dv_r;
  logic [PCW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [IW:0]    trial;
  logic           fits;
  logic [IW:0]    diff;

  assign trial = {rem_r, q_r[PW-1]};
  assign fits  = trial >= {1'b0, dv_r};
  assign diff  = trial - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dv_r   <= divisor;
      end else if (busy_r) begin
        // The remainder stays below the divisor, so it fits the narrow register.
        rem_r <= fits ? diff[IW-1:0] : trial[IW-1:0];
        q_r   <= {q_r[PW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == PCW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

// ===== verif/binomial_coefficient_saturating_tb.sv =====
`timescale 1ns / 100ps
module binomial_coefficient_saturating_tb;
  import bcs_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2000;
  localparam int HOLD_CYCLES = 600;
  localparam int BATCH_ITEMS = 385;
  localparam int MAX_REPORTS = 10;

  // Packed so that set_size lands in the low half of in_tdata.
  typedef struct packed {
    logic signed [NW-1:0] choose_count;
    logic signed [NW-1:0] set_size;
  } operand_pair_t;

  typedef struct {
    logic signed [NW-1:0] set_size;
    logic signed [NW-1:0] choose_count;
    logic [CW-1:0]        combinations;
  } combo_expect_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;      // [31:0] set_size, [63:32] choose_count
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [30:0] combinations, [31] zero

  operand_pair_t pending_pairs[$];
  combo_expect_t awaited_combos[$];

  bit in_fire;
  bit out_fire;
  bit rx_hold;
  int tx_idle_pct;
  int rx_idle_pct;
  int issued_count;
  int accepted_count;
  int checked_count;
  int error_count;
  int zero_count;
  int sat_count;
  int exact_count;
  int quiet_cycles;

  binomial_coefficient_saturating DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Multiplicative binomial with early exit once the running value passes
  // the 31-bit ceiling.
  function automatic logic [CW-1:0] choose_saturated(logic signed [NW-1:0] n,
                                                     logic signed [NW-1:0] k);
    longint nn;
    longint kk;
    longint unsigned acc;
    longint unsigned base;
    longint unsigned r;
    nn = n;
    kk = k;
    acc = 1;
    if (nn < 0 || kk < 0 || kk > nn) return '0;
    if (kk > nn - kk) kk = nn - kk;
    base = nn - kk;
    for (r = 1; r <= kk; r++) begin
      acc = acc * (base + r) / r;
      if (acc > COMB_SAT) return COMB_SAT;
    end
    return acc[CW-1:0];
  endfunction

  function automatic operand_pair_t random_operands();
    operand_pair_t p;
    int unsigned pick;
    pick = $urandom_range(99);
    p.set_size = $urandom;
    p.choose_count = $urandom;
    if (pick < 40) begin
      // Small sets hold the long multi-round computations.
      p.set_size = $urandom_range(40);
      p.choose_count = $urandom_range(p.set_size + 2);
    end else if (pick < 60) begin
      p.set_size = $urandom_range(100000, 41);
      p.choose_count = $urandom_range(6);
    end else if (pick < 72) begin
      p.set_size = 32'h7FFF_FFFF - $urandom_range(255);
      if ($urandom_range(1)) p.choose_count = $urandom_range(3);
      else p.choose_count = p.set_size - $urandom_range(3);
    end else if (pick < 82) begin
      p.set_size = $urandom_range(40);
      p.choose_count = $urandom_range(40);
      if ($urandom_range(1)) p.set_size[NW-1] = 1'b1;
      else p.choose_count[NW-1] = 1'b1;
    end
    return p;
  endfunction

  task automatic push_pair(logic signed [NW-1:0] n, logic signed [NW-1:0] k);
    operand_pair_t p;
    p.set_size = n;
    p.choose_count = k;
    pending_pairs.push_back(p);
    issued_count++;
  endtask

  // Returns at a rising edge once every issued transaction has been accepted
  // and answered.
  task automatic await_all_results();
    @(negedge clk);
    while (accepted_count != issued_count || awaited_combos.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic issue_random_batch(int count, int tx_idle, int rx_idle);
    tx_idle_pct = tx_idle;
    rx_idle_pct = rx_idle;
    repeat (count) begin
      pending_pairs.push_back(random_operands());
      issued_count++;
    end
    await_all_results();
  endtask

  task automatic note_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Sender: holds the current transaction until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_pairs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    combo_expect_t exp_item;
    operand_pair_t taken;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      if (awaited_combos.size() == 0) begin
        note_mismatch($sformatf("unexpected result 0x%08h", out_tdata));
      end else begin
        exp_item = awaited_combos.pop_front();
        checked_count++;
        if (out_tdata !== {1'b0, exp_item.combinations})
          note_mismatch($sformatf("C(%0d,%0d): expected %0d, got %0d (tdata 0x%08h)",
                                  exp_item.set_size, exp_item.choose_count,
                                  exp_item.combinations, out_tdata[CW-1:0], out_tdata));
      end
    end
    if (in_fire) begin
      taken = in_tdata;
      exp_item.set_size = taken.set_size;
      exp_item.choose_count = taken.choose_count;
      exp_item.combinations = choose_saturated(taken.set_size, taken.choose_count);
      awaited_combos.push_back(exp_item);
      accepted_count++;
      if (exp_item.combinations == '0) zero_count++;
      else if (exp_item.combinations == COMB_SAT) sat_count++;
      else exact_count++;
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if (in_tvalid && in_tready || out_tvalid && out_tready) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited_combos.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    tx_idle_pct = 11;
    rx_idle_pct = 70;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    push_pair(0, 0);
    push_pair(5, 0);
    push_pair(5, 5);
    push_pair(10, 3);
    push_pair(3, 4);
    push_pair(-1, 0);
    push_pair(0, -1);
    push_pair(-5, -7);
    push_pair(32'sh8000_0000, 32'sh8000_0000);
    push_pair(32'sh8000_0000, 5);
    push_pair(5, 32'sh8000_0000);
    push_pair(5, 32'sh7FFF_FFFF);
    push_pair(32'sh7FFF_FFFF, -1);
    push_pair(32'sh7FFF_FFFF, 0);
    push_pair(32'sh7FFF_FFFF, 1);
    push_pair(32'sh7FFF_FFFF, 2);
    push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFE);
    push_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_pair(33, 16);
    push_pair(33, 17);
    push_pair(34, 17);
    push_pair(67, 3);
    await_all_results();

    issue_random_batch(BATCH_ITEMS, 11, 70);

    // Hold the output off while cheap transactions keep arriving, so the
    // block fills up and pushes back on its input.
    tx_idle_pct = 0;
    rx_hold = 1'b1;
    repeat (12) begin
      n = $urandom_range(20);
      if ($urandom_range(1)) push_pair(n, n + 1 + $urandom_range(5));
      else push_pair(n, 0);
    end
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
    await_all_results();

    issue_random_batch(BATCH_ITEMS, 70, 11);
    issue_random_batch(BATCH_ITEMS, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_combos.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", awaited_combos.size()));
    $display("Checked %0d of %0d transactions: %0d zero, %0d saturated, %0d exact.",
             checked_count, accepted_count, zero_count, sat_count, exact_count);
    $display("Stalls ran on both channels, plus one long output hold; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bcs_pkg.sv
rtl/bcs_mul.sv
rtl/bcs_div.sv
rtl/binomial_coefficient_saturating.sv
verif/binomial_coefficient_saturating_tb.sv
